[sv/rvs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_pkg
// Shared types, constants and helpers for the RRIP victim selector.
// ----------------------------------------------------------------------------
package rvs_pkg;

   localparam int DEFAULT_WAYS = 16;

   localparam int RRPV_W = 8;
   localparam int WAY_W  = 4;
   localparam int FP_W   = 8;
   localparam int WIU_W  = 5;
   localparam int BIT_W  = 3;
   localparam int CSR_W  = 8;

   localparam logic [RRPV_W-1:0] MAX_RRPV_RESET    = 8'd3;
   localparam logic [WIU_W-1:0]  WAYS_IN_USE_RESET = 5'd16;

   typedef enum logic [2:0] {
      ACT_AGE        = 3'd0,
      ACT_HIT        = 3'd1,
      ACT_FILL       = 3'd2,
      ACT_VICTIM     = 3'd3,
      ACT_INVALIDATE = 3'd4,
      ACT_INSERT     = 3'd5
   } action_type;

   typedef enum logic {
      CSR_MAX_RRPV    = 1'b0,
      CSR_WAYS_IN_USE = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_AGE,
      ST_SCAN,
      ST_VFIN,
      ST_HOLD
   } state_type;

   typedef struct packed {
      logic [WAY_W-1:0] victim_way;
      logic             victim_valid;
      logic             insert_allowed;
   } result_type;

   // Counter given to a line filled from the last level cache without reuse
   // hints: the emptier the footprint, the further the predicted re-reference.
   function automatic logic [RRPV_W-1:0] density_rrpv(input logic [RRPV_W-1:0] top,
                                                      input logic [FP_W-1:0]   fp);
      logic [3:0]  pop;
      logic [3:0]  empty;
      logic [11:0] prod;
      pop = 4'd0;
      for (int i = 0; i < FP_W; i++) begin
         pop = pop + 4'(fp[i]);
      end
      empty = 4'd8 - pop;
      prod  = 12'(empty) * 12'(top);
      return prod[10:3];
   endfunction

endpackage

[sv/rvs_ctr_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rvs_ctr_mem
// Synchronous counter store, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rvs_ctr_mem #(
   parameter int WAYS = rvs_pkg::DEFAULT_WAYS
) (
   input  logic                        clock,
   input  logic                        rd_en,
   input  logic [$clog2(WAYS)-1:0]     rd_addr,
   output logic [rvs_pkg::RRPV_W-1:0]  rd_data,
   input  logic                        wr_en,
   input  logic [$clog2(WAYS)-1:0]     wr_addr,
   input  logic [rvs_pkg::RRPV_W-1:0]  wr_data
);

   logic [rvs_pkg::RRPV_W-1:0] mem [WAYS];
   logic [rvs_pkg::RRPV_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/rrip_victim_select_with_priority.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrip_victim_select_with_priority
// Per-set RRIP replacement state with a low-priority mark per way.
// ----------------------------------------------------------------------------
//
//   channel | ports                        | direction | moves
//   --------+------------------------------+-----------+--------------------
//   req     | req_valid/req_stall + fields | in        | one item per action
//   rsp     | rsp_valid/rsp_stall + fields | out       | one result per item
//   csr     | csr_we/csr_index/csr_wdata   | in        | register writes
//
// Hit, fill, invalidate, insert check and an age with nothing to do put their
// result in the output register, or in the hold register if the output stalls.
// A victim request scans max(min(ways_in_use, WAYS), 1) ways of the counter memory,
// one way a cycle; an age with a pending gap sweeps every way by read-modify-write.
// Reset is synchronous; the counter memory needs no clearing pass.
// A new item is taken while a finished result still waits in the output
// register; the following result then holds until the output is taken.
// ----------------------------------------------------------------------------
module rrip_victim_select_with_priority #(
   parameter int WAYS = rvs_pkg::DEFAULT_WAYS
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [2:0]                  req_action,
   input  logic [rvs_pkg::WAY_W-1:0]   req_way,
   input  logic [rvs_pkg::FP_W-1:0]    req_footprint,
   input  logic                        req_from_llc,
   input  logic                        req_high_reuse,
   input  logic                        req_hub_node,
   input  logic                        req_accessed_before,
   input  logic [rvs_pkg::BIT_W-1:0]   req_bit_index,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [rvs_pkg::WAY_W-1:0]   rsp_victim_way,
   output logic                        rsp_victim_valid,
   output logic                        rsp_insert_allowed,

   input  logic                        csr_we,
   input  logic                        csr_index,
   input  logic [rvs_pkg::CSR_W-1:0]   csr_wdata
);

   localparam int IDX_W = $clog2(WAYS);
   localparam int CNT_W = $clog2(WAYS + 1);
   localparam int R_W   = rvs_pkg::RRPV_W;

   rvs_pkg::state_type     state_ff, state_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rvs_pkg::result_type    rsp_ff, rsp_in;
   rvs_pkg::result_type    hold_ff, hold_in;

   logic [WAYS-1:0]        invalid_ff, invalid_in;
   logic [WAYS-1:0]        mark_ff, mark_in;
   logic [R_W-1:0]         gap_ff, gap_in;
   logic                   gap_pending_ff, gap_pending_in;
   logic [R_W-1:0]         max_rrpv_ff, max_rrpv_in;
   logic [rvs_pkg::WIU_W-1:0] wiu_ff, wiu_in;

   logic [IDX_W-1:0]       addr_ff, addr_in;
   logic                   iss_ff, iss_in;
   logic                   ev_vld_ff, ev_vld_in;
   logic                   ev_last_ff, ev_last_in;
   logic [IDX_W-1:0]       ev_idx_ff, ev_idx_in;

   logic                   lp_found_ff, lp_found_in;
   logic [IDX_W-1:0]       lp_idx_ff, lp_idx_in;
   logic [R_W-1:0]         lp_ctr_ff, lp_ctr_in;
   logic                   any_found_ff, any_found_in;
   logic [IDX_W-1:0]       any_idx_ff, any_idx_in;
   logic [R_W-1:0]         any_ctr_ff, any_ctr_in;
   logic [R_W-1:0]         ctr0_ff, ctr0_in;

   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic [R_W-1:0]         rd_data;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   logic [R_W-1:0]         wr_data;

   rvs_ctr_mem #(.WAYS(WAYS)) u_ctr_mem (
      .clock   (clock),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   always_comb begin
      logic                accept;
      logic                out_free;
      logic                finish;
      rvs_pkg::result_type res;
      logic                wok;
      logic [IDX_W-1:0]    way_sel;
      logic [R_W-1:0]      top;
      logic [R_W-1:0]      fill_val;
      logic                hub_plain;
      logic [CNT_W-1:0]    n_srch;
      logic [CNT_W-1:0]    n_eff;
      logic [IDX_W-1:0]    lim_m1;
      logic [R_W:0]        sum;
      logic [R_W-1:0]      aged;
      logic                in_rng;
      logic                ev_ok;
      logic [IDX_W-1:0]    cand;
      logic [R_W-1:0]      cand_ctr;
      logic                cand_ok;
      logic [R_W-1:0]      headroom;
      logic                fp_bit;

      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_in         = rsp_ff;
      hold_in        = hold_ff;
      invalid_in     = invalid_ff;
      mark_in        = mark_ff;
      gap_in         = gap_ff;
      gap_pending_in = gap_pending_ff;
      max_rrpv_in    = max_rrpv_ff;
      wiu_in         = wiu_ff;
      addr_in        = addr_ff;
      iss_in         = iss_ff;
      ev_vld_in      = 1'b0;
      ev_last_in     = 1'b0;
      ev_idx_in      = addr_ff;
      lp_found_in    = lp_found_ff;
      lp_idx_in      = lp_idx_ff;
      lp_ctr_in      = lp_ctr_ff;
      any_found_in   = any_found_ff;
      any_idx_in     = any_idx_ff;
      any_ctr_in     = any_ctr_ff;
      ctr0_in        = ctr0_ff;
      rd_en          = 1'b0;
      rd_addr        = addr_ff;
      wr_en          = 1'b0;
      wr_addr        = ev_idx_ff;
      wr_data        = rd_data;
      finish         = 1'b0;
      res            = '0;

      accept    = req_valid && !req_stall;
      out_free  = !rsp_valid_ff || !rsp_stall;
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      wok       = 32'(req_way) < 32'(WAYS);
      way_sel   = IDX_W'(req_way);
      top       = (max_rrpv_ff != '0) ? max_rrpv_ff - 1'b1 : '0;
      hub_plain = req_hub_node && !req_high_reuse;
      if (req_from_llc) begin
         if (req_high_reuse) begin
            fill_val = top;
         end else if (req_accessed_before) begin
            fill_val = '0;
         end else begin
            fill_val = rvs_pkg::density_rrpv(top, req_footprint);
         end
      end else begin
         fill_val = hub_plain ? '0 : top;
      end
      fp_bit = req_footprint[req_bit_index];

      n_srch = (32'(wiu_ff) < 32'(WAYS)) ? CNT_W'(wiu_ff) : CNT_W'(WAYS);
      // Way 0 is always read so that its counter is known when no way is
      // searched.
      n_eff  = (n_srch == '0) ? CNT_W'(1) : n_srch;
      lim_m1 = IDX_W'(n_eff - 1'b1);

      sum  = {1'b0, rd_data} + {1'b0, gap_ff};
      aged = (invalid_ff[ev_idx_ff] || (sum > {1'b0, max_rrpv_ff})) ?
             max_rrpv_ff : sum[R_W-1:0];

      in_rng = CNT_W'(ev_idx_ff) < n_srch;
      ev_ok  = in_rng && !invalid_ff[ev_idx_ff];

      cand     = '0;
      cand_ctr = ctr0_ff;
      if (lp_found_ff) begin
         cand     = lp_idx_ff;
         cand_ctr = lp_ctr_ff;
      end else if (any_found_ff) begin
         cand     = any_idx_ff;
         cand_ctr = any_ctr_ff;
      end
      cand_ok  = !invalid_ff[cand];
      headroom = max_rrpv_ff - cand_ctr;

      unique case (state_ff)
         rvs_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_action)
                  rvs_pkg::ACT_AGE: begin
                     // The gap stays in place during the sweep, which uses it.
                     if (gap_pending_ff && (gap_ff < max_rrpv_ff)) begin
                        addr_in  = '0;
                        iss_in   = 1'b1;
                        state_in = rvs_pkg::ST_AGE;
                     end else begin
                        gap_in         = '0;
                        gap_pending_in = 1'b0;
                        finish         = 1'b1;
                     end
                  end
                  rvs_pkg::ACT_HIT: begin
                     if (wok) begin
                        wr_en               = 1'b1;
                        wr_addr             = way_sel;
                        wr_data             = '0;
                        invalid_in[way_sel] = 1'b0;
                     end
                     finish = 1'b1;
                  end
                  rvs_pkg::ACT_FILL: begin
                     if (wok) begin
                        wr_en               = 1'b1;
                        wr_addr             = way_sel;
                        wr_data             = fill_val;
                        invalid_in[way_sel] = 1'b0;
                        mark_in[way_sel]    = !hub_plain;
                     end
                     finish = 1'b1;
                  end
                  rvs_pkg::ACT_VICTIM: begin
                     addr_in      = '0;
                     iss_in       = 1'b1;
                     lp_found_in  = 1'b0;
                     any_found_in = 1'b0;
                     state_in     = rvs_pkg::ST_SCAN;
                  end
                  rvs_pkg::ACT_INVALIDATE: begin
                     if (wok) begin
                        invalid_in[way_sel] = 1'b1;
                     end
                     finish = 1'b1;
                  end
                  rvs_pkg::ACT_INSERT: begin
                     res.insert_allowed = !req_high_reuse && !(req_hub_node && !fp_bit);
                     finish             = 1'b1;
                  end
                  default: begin
                     finish = 1'b1;
                  end
               endcase
            end
         end

         rvs_pkg::ST_AGE: begin
            if (iss_ff) begin
               rd_en      = 1'b1;
               ev_vld_in  = 1'b1;
               ev_last_in = (addr_ff == IDX_W'(WAYS - 1));
               if (addr_ff == IDX_W'(WAYS - 1)) begin
                  iss_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (ev_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = ev_idx_ff;
               wr_data = aged;
            end
            if (ev_last_ff) begin
               invalid_in     = '0;
               gap_in         = '0;
               gap_pending_in = 1'b0;
               finish         = 1'b1;
            end
         end

         rvs_pkg::ST_SCAN: begin
            if (iss_ff) begin
               rd_en      = 1'b1;
               ev_vld_in  = 1'b1;
               ev_last_in = (addr_ff == lim_m1);
               if (addr_ff == lim_m1) begin
                  iss_in = 1'b0;
               end else begin
                  addr_in = addr_ff + 1'b1;
               end
            end
            if (ev_vld_ff) begin
               if (ev_idx_ff == '0) begin
                  ctr0_in = rd_data;
               end
               // Strictly greater keeps the lowest index among equal counters.
               if (ev_ok && mark_ff[ev_idx_ff] && (!lp_found_ff || rd_data > lp_ctr_ff)) begin
                  lp_found_in = 1'b1;
                  lp_idx_in   = ev_idx_ff;
                  lp_ctr_in   = rd_data;
               end
               if (ev_ok && (!any_found_ff || rd_data > any_ctr_ff)) begin
                  any_found_in = 1'b1;
                  any_idx_in   = ev_idx_ff;
                  any_ctr_in   = rd_data;
               end
               if (ev_last_ff) begin
                  state_in = rvs_pkg::ST_VFIN;
               end
            end
         end

         rvs_pkg::ST_VFIN: begin
            if (cand_ok && (cand_ctr < max_rrpv_ff)) begin
               if (!gap_pending_ff || (headroom < gap_ff)) begin
                  gap_in = headroom;
               end
               gap_pending_in = 1'b1;
            end
            res.victim_way   = rvs_pkg::WAY_W'(cand);
            res.victim_valid = cand_ok;
            finish           = 1'b1;
         end

         rvs_pkg::ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = hold_ff;
               state_in     = rvs_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rvs_pkg::ST_IDLE;
         end
      endcase

      if (finish) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_in       = res;
            state_in     = rvs_pkg::ST_IDLE;
         end else begin
            hold_in  = res;
            state_in = rvs_pkg::ST_HOLD;
         end
      end

      if (csr_we) begin
         unique case (csr_index)
            rvs_pkg::CSR_MAX_RRPV:    max_rrpv_in = csr_wdata;
            rvs_pkg::CSR_WAYS_IN_USE: wiu_in      = csr_wdata[rvs_pkg::WIU_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= rvs_pkg::ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         invalid_ff     <= '1;
         mark_ff        <= '0;
         gap_ff         <= '0;
         gap_pending_ff <= 1'b0;
         max_rrpv_ff    <= rvs_pkg::MAX_RRPV_RESET;
         wiu_ff         <= rvs_pkg::WAYS_IN_USE_RESET;
         iss_ff         <= 1'b0;
         ev_vld_ff      <= 1'b0;
         ev_last_ff     <= 1'b0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         invalid_ff     <= invalid_in;
         mark_ff        <= mark_in;
         gap_ff         <= gap_in;
         gap_pending_ff <= gap_pending_in;
         max_rrpv_ff    <= max_rrpv_in;
         wiu_ff         <= wiu_in;
         iss_ff         <= iss_in;
         ev_vld_ff      <= ev_vld_in;
         ev_last_ff     <= ev_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff       <= rsp_in;
      hold_ff      <= hold_in;
      addr_ff      <= addr_in;
      ev_idx_ff    <= ev_idx_in;
      lp_found_ff  <= lp_found_in;
      lp_idx_ff    <= lp_idx_in;
      lp_ctr_ff    <= lp_ctr_in;
      any_found_ff <= any_found_in;
      any_idx_ff   <= any_idx_in;
      any_ctr_ff   <= any_ctr_in;
      ctr0_ff      <= ctr0_in;
   end

   assign req_stall          = (state_ff != rvs_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_victim_way     = rsp_ff.victim_way;
   assign rsp_victim_valid   = rsp_ff.victim_valid;
   assign rsp_insert_allowed = rsp_ff.insert_allowed;

endmodule
